[rtl/core/ihp_pkg.sv]
// Shared types and constants for the indexed min-heap of group pairs.
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int KEY_W       = 24;
  localparam int GROUP_W     = 6;
  localparam int PAIR_W      = 2 * GROUP_W;
  localparam int GROUP_COUNT = 64;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;
  localparam int TOTAL_W     = 12;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_EXTRACT = 3'd1,
    OP_PEEK    = 3'd2,
    OP_CHANGE  = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_EXISTS  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_DUP      = 3'd4,
    ST_BADPAIR  = 3'd5
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PAIR_W-1:0] pair;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic    ready;
    logic    clr;
    logic    load;
    logic    look;
    logic    rd_old;
    logic    st_en;
    status_t st;
    logic    empty_key;
    logic    take_min;
    logic    take_present;
    logic    ins;
    logic    ext;
    logic    rem;
    logic    chg;
    logic    up_rd;
    logic    up_mv;
    logic    dn_rd;
    logic    dn_mv;
    logic    place;
    logic    respond;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic [OP_W-1:0] op;
    logic pair_ok;
    logic pos_hit;
    logic empty;
    logic full;
    logic one_left;
    logic rem_last;
    logic chg_less;
    logic root;
    logic up_less;
    logic dn_leaf;
    logic dn_less;
    logic moved;
    logic out_busy;
  } stat_t;

endpackage

[rtl/core/ihp_ifs.sv]
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface ihp_req_if;
  logic                           valid;
  logic                           ready;
  logic [ihp_pkg::OP_W-1:0]       req_type;
  logic [ihp_pkg::KEY_W-1:0]      key;
  logic [ihp_pkg::GROUP_W-1:0]    group_a;
  logic [ihp_pkg::GROUP_W-1:0]    group_b;
  modport source (output valid, req_type, key, group_a, group_b, input ready);
  modport sink (input valid, req_type, key, group_a, group_b, output ready);
endinterface

interface ihp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ihp_pkg::STATUS_W-1:0]   status;
  logic [ihp_pkg::KEY_W-1:0]      min_key;
  logic [ihp_pkg::GROUP_W-1:0]    min_low_group;
  logic [ihp_pkg::GROUP_W-1:0]    min_high_group;
  logic                           present;
  logic [ihp_pkg::TOTAL_W-1:0]    entry_total;
  modport source (output valid, status, min_key, min_low_group, min_high_group,
                  present, entry_total, input ready);
  modport sink (input valid, status, min_key, min_low_group, min_high_group,
                present, entry_total, output ready);
endinterface

[rtl/core/ihp_dp.sv]
// Heap datapath: slot memory, position table, sift registers and result register.
`timescale 1ns / 1ps
module ihp_dp #(
  parameter int HEAP_SLOTS = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ihp_pkg::cmd_t                  cmd,
  output ihp_pkg::stat_t                 stat,
  input  logic [ihp_pkg::OP_W-1:0]       in_type,
  input  logic [ihp_pkg::KEY_W-1:0]      in_key,
  input  logic [ihp_pkg::GROUP_W-1:0]    in_a,
  input  logic [ihp_pkg::GROUP_W-1:0]    in_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ihp_pkg::STATUS_W-1:0]   out_status,
  output logic [ihp_pkg::KEY_W-1:0]      out_key,
  output logic [ihp_pkg::GROUP_W-1:0]    out_lo,
  output logic [ihp_pkg::GROUP_W-1:0]    out_hi,
  output logic                           out_present,
  output logic [ihp_pkg::TOTAL_W-1:0]    out_total
);
  localparam int SW = (HEAP_SLOTS > 1) ? $clog2(HEAP_SLOTS) : 1;
  localparam int CW = $clog2(HEAP_SLOTS + 1);
  localparam int XW = SW + 2;
  localparam int PW = ihp_pkg::PAIR_W;
  localparam int GW = ihp_pkg::GROUP_W;

  ihp_pkg::entry_t heap_mem [HEAP_SLOTS];
  logic [SW:0]     pos_mem [1 << PW];

  ihp_pkg::entry_t ra_q, rb_q, e, hw_data, child;
  logic [SW:0]     pv_q, pw_data;
  logic [SW-1:0]   ha_addr, hb_addr, hw_addr, idx, parent, child_idx;
  logic [PW-1:0]   pw_addr, pi, clr_cnt;
  logic            hw_en, pw_en;
  logic [CW-1:0]   count, cnt_m1;
  logic [XW-1:0]   l_x, r_x, cnt_x;
  logic            pick_l, pick_r, r_ok;
  logic [ihp_pkg::KEY_W-1:0] ref_key;

  logic [ihp_pkg::OP_W-1:0]  r_op;
  logic [ihp_pkg::KEY_W-1:0] r_key;
  logic [GW-1:0]             r_lo, r_hi;
  logic                      moved;
  logic [ihp_pkg::STATUS_W-1:0] res_status;
  logic [ihp_pkg::KEY_W-1:0]    res_key;
  logic [GW-1:0]                res_lo, res_hi;
  logic                         res_present;

  assign pi     = {r_lo, r_hi};
  assign cnt_m1 = count - 1'b1;
  assign parent = (idx - 1'b1) >> 1;
  assign l_x    = {1'b0, idx, 1'b0} + XW'(1);
  assign r_x    = {1'b0, idx, 1'b0} + XW'(2);
  assign cnt_x  = XW'(count);
  assign r_ok   = r_x < cnt_x;
  assign pick_l = ra_q.key < e.key;
  assign ref_key = pick_l ? ra_q.key : e.key;
  assign pick_r = r_ok && (rb_q.key < ref_key);
  assign child  = pick_r ? rb_q : ra_q;
  assign child_idx = pick_r ? r_x[SW-1:0] : l_x[SW-1:0];

  always_comb begin
    stat.clr_done = (clr_cnt == {PW{1'b1}});
    stat.op       = r_op;
    stat.pair_ok  = (r_lo != r_hi) && ({1'b0, r_hi} < (GW+1)'(ihp_pkg::GROUP_COUNT));
    stat.pos_hit  = pv_q[SW];
    stat.empty    = (count == '0);
    stat.full     = (count == CW'(HEAP_SLOTS));
    stat.one_left = (count == CW'(1));
    stat.rem_last = (pv_q[SW-1:0] == cnt_m1[SW-1:0]);
    stat.chg_less = r_key < ra_q.key;
    stat.root     = (idx == '0);
    stat.up_less  = e.key < ra_q.key;
    stat.dn_leaf  = !(l_x < cnt_x);
    stat.dn_less  = pick_l || pick_r;
    stat.moved    = moved;
    stat.out_busy = out_valid && !out_ready;
  end

  always_comb begin
    ha_addr = '0;
    hb_addr = cnt_m1[SW-1:0];
    if (cmd.rd_old) begin
      ha_addr = pv_q[SW-1:0];
    end else if (cmd.up_rd) begin
      ha_addr = parent;
    end else if (cmd.dn_rd) begin
      ha_addr = l_x[SW-1:0];
      hb_addr = r_x[SW-1:0];
    end
    hw_en   = 1'b0;
    hw_addr = idx;
    hw_data = e;
    pw_en   = 1'b0;
    pw_addr = e.pair;
    pw_data = {1'b1, idx};
    if (cmd.clr) begin
      pw_en   = 1'b1;
      pw_addr = clr_cnt;
      pw_data = '0;
    end else if (cmd.ext) begin
      pw_en   = 1'b1;
      pw_addr = ra_q.pair;
      pw_data = '0;
    end else if (cmd.rem) begin
      pw_en   = 1'b1;
      pw_addr = pi;
      pw_data = '0;
    end else if (cmd.up_mv) begin
      hw_en   = 1'b1;
      hw_data = ra_q;
      pw_en   = 1'b1;
      pw_addr = ra_q.pair;
    end else if (cmd.dn_mv) begin
      hw_en   = 1'b1;
      hw_data = child;
      pw_en   = 1'b1;
      pw_addr = child.pair;
    end else if (cmd.place) begin
      hw_en = 1'b1;
      pw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    ra_q <= heap_mem[ha_addr];
    rb_q <= heap_mem[hb_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    pv_q <= pos_mem[pi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.ins) begin
        count <= count + 1'b1;
      end else if (cmd.ext || cmd.rem) begin
        count <= cnt_m1;
      end
      if (cmd.respond) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op        <= in_type;
      r_key       <= in_key;
      r_lo        <= (in_a < in_b) ? in_a : in_b;
      r_hi        <= (in_a < in_b) ? in_b : in_a;
      res_status  <= ihp_pkg::ST_OK;
      res_key     <= '0;
      res_lo      <= '0;
      res_hi      <= '0;
      res_present <= 1'b0;
    end
    if (cmd.st_en) begin
      res_status <= cmd.st;
    end
    if (cmd.empty_key) begin
      res_key <= '1;
    end
    if (cmd.take_min) begin
      res_key <= ra_q.key;
      res_lo  <= ra_q.pair[PW-1:GW];
      res_hi  <= ra_q.pair[GW-1:0];
    end
    if (cmd.take_present) begin
      res_present <= pv_q[SW];
    end
    if (cmd.ins) begin
      e     <= '{key: r_key, pair: pi};
      idx   <= count[SW-1:0];
      moved <= 1'b0;
    end else if (cmd.ext) begin
      e     <= rb_q;
      idx   <= '0;
      moved <= 1'b0;
    end else if (cmd.rem) begin
      e     <= rb_q;
      idx   <= pv_q[SW-1:0];
      moved <= 1'b0;
    end else if (cmd.chg) begin
      e     <= '{key: r_key, pair: pi};
      idx   <= pv_q[SW-1:0];
      moved <= 1'b0;
    end else if (cmd.up_mv) begin
      idx   <= parent;
      moved <= 1'b1;
    end else if (cmd.dn_mv) begin
      idx   <= child_idx;
    end
    if (cmd.respond) begin
      out_status  <= res_status;
      out_key     <= res_key;
      out_lo      <= res_lo;
      out_hi      <= res_hi;
      out_present <= res_present;
      out_total   <= ihp_pkg::TOTAL_W'(count);
    end
  end

endmodule

[rtl/core/ihp_ctrl.sv]
// Request sequencer: decodes each request and steps the sift loops.
`timescale 1ns / 1ps
module ihp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  ihp_pkg::stat_t stat,
  output ihp_pkg::cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_DECIDE, S_OLD, S_CHG,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_RESP
  } state_t;

  state_t state, state_next;
  logic   dn_after, dn_after_next;

  always_comb begin
    cmd           = '0;
    cmd.st        = ihp_pkg::ST_OK;
    state_next    = state;
    dn_after_next = dn_after;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_RESP;
        case (stat.op)
          ihp_pkg::OP_EXTRACT, ihp_pkg::OP_PEEK: begin
            if (stat.empty) begin
              cmd.st_en     = 1'b1;
              cmd.st        = ihp_pkg::ST_EMPTY;
              cmd.empty_key = 1'b1;
            end else begin
              cmd.take_min = 1'b1;
              if (stat.op == ihp_pkg::OP_EXTRACT) begin
                cmd.ext = 1'b1;
                if (!stat.one_left) state_next = S_DN_RD;
              end
            end
          end
          ihp_pkg::OP_INSERT, ihp_pkg::OP_CHANGE, ihp_pkg::OP_REMOVE,
          ihp_pkg::OP_EXISTS: begin
            if (!stat.pair_ok) begin
              cmd.st_en = 1'b1;
              cmd.st    = ihp_pkg::ST_BADPAIR;
            end else if (stat.op == ihp_pkg::OP_EXISTS) begin
              cmd.take_present = 1'b1;
            end else if (stat.op == ihp_pkg::OP_INSERT) begin
              if (stat.pos_hit) begin
                cmd.st_en = 1'b1;
                cmd.st    = ihp_pkg::ST_DUP;
              end else if (stat.full) begin
                cmd.st_en = 1'b1;
                cmd.st    = ihp_pkg::ST_FULL;
              end else begin
                cmd.ins       = 1'b1;
                dn_after_next = 1'b0;
                state_next    = S_UP_RD;
              end
            end else if (!stat.pos_hit) begin
              cmd.st_en = 1'b1;
              cmd.st    = ihp_pkg::ST_NOTFOUND;
            end else if (stat.op == ihp_pkg::OP_CHANGE) begin
              state_next = S_OLD;
            end else begin
              cmd.rem = 1'b1;
              if (!stat.rem_last) begin
                dn_after_next = 1'b1;
                state_next    = S_UP_RD;
              end
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = S_CHG;
      end
      S_CHG: begin
        cmd.chg       = 1'b1;
        dn_after_next = 1'b0;
        state_next    = stat.chg_less ? S_UP_RD : S_DN_RD;
      end
      S_UP_RD: begin
        if (!stat.root) begin
          cmd.up_rd  = 1'b1;
          state_next = S_UP_CMP;
        end else if (dn_after && !stat.moved) begin
          state_next = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd.up_mv  = 1'b1;
          state_next = S_UP_RD;
        end else if (dn_after && !stat.moved) begin
          state_next = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_DN_RD: begin
        if (stat.dn_leaf) begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.dn_rd  = 1'b1;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_less) begin
          cmd.dn_mv  = 1'b1;
          state_next = S_DN_RD;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      dn_after <= 1'b0;
    end else begin
      state    <= state_next;
      dn_after <= dn_after_next;
    end
  end

endmodule

[rtl/core/indexed_min_heap_pairs.sv]
// Indexed binary min-heap of keyed group pairs, top level.
// Peek, exists, empty and rejected requests pass through look, decide and respond; an update also
// sifts, each level a read then a compare and move, the longest path being a key change.
// Requests are handled one at a time, the next taken the cycle after the result registers;
// the per-level read-compare-write loop on the single slot memory sets the rate.
// Reset: a clearing pass over all 4096 position-table entries invalidates them; no request is taken until it ends.
`timescale 1ns / 1ps
module indexed_min_heap_pairs #(
  parameter int HEAP_SLOTS = 2048
) (
  input logic       clk,
  input logic       rst,
  ihp_req_if.sink   req,
  ihp_rsp_if.source rsp
);
  ihp_pkg::cmd_t  cmd;
  ihp_pkg::stat_t stat;

  assign req.ready = cmd.ready;

  ihp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  ihp_dp #(.HEAP_SLOTS(HEAP_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_type     (req.req_type),
    .in_key      (req.key),
    .in_a        (req.group_a),
    .in_b        (req.group_b),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_key     (rsp.min_key),
    .out_lo      (rsp.min_low_group),
    .out_hi      (rsp.min_high_group),
    .out_present (rsp.present),
    .out_total   (rsp.entry_total)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in flight");

  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ihp_pkg::ST_EMPTY) |->
      (rsp.min_key == {ihp_pkg::KEY_W{1'b1}} && rsp.entry_total == '0))
    else $error("empty response with wrong key or nonzero total");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.ready) |-> !(cmd.ins || cmd.ext || cmd.rem || cmd.place))
    else $error("heap update while waiting for a request");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the indexed min-heap of group pairs.
`timescale 1ns / 1ps
module tb_top;

  localparam int SLOTS = 2048;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ihp_req_if req_ch();
  ihp_rsp_if rsp_ch();

  indexed_min_heap_pairs #(.HEAP_SLOTS(SLOTS)) i_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] key;
    logic [5:0]  ga;
    logic [5:0]  gb;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] min_key;
    logic [5:0]  lo;
    logic [5:0]  hi;
    logic        present;
    logic [11:0] total;
  } answer_t;

  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  ans;
  } row_t;

  // shadow heap
  logic [23:0] hk[SLOTS];
  logic [11:0] hp[SLOTS];
  int          ppos[4096];
  bit          pval[4096];
  int          hcount;

  answer_t pending[$];
  row_t    rows[$];
  int      fails;
  int      mismatches;
  int      idle_cycles;
  int      sent;
  int      got;
  bit      no_idle;
  bit      rsp_hold;

  function automatic void swap_slots(int a, int b);
    logic [23:0] k;
    logic [11:0] p;
    k = hk[a]; p = hp[a];
    hk[a] = hk[b]; hp[a] = hp[b];
    hk[b] = k; hp[b] = p;
    ppos[hp[a]] = a;
    ppos[hp[b]] = b;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (hk[i] < hk[p]) begin
        swap_slots(i, p);
        i = p;
      end else break;
    end
  endfunction

  function automatic void sift_down(int i);
    int l, r, m;
    forever begin
      l = 2 * i + 1; r = 2 * i + 2; m = i;
      if (l < hcount && hk[l] < hk[m]) m = l;
      if (r < hcount && hk[r] < hk[m]) m = r;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  function automatic void fill_from_last(int s);
    int last;
    last = hcount - 1;
    hcount = last;
    if (s != last) begin
      hk[s] = hk[last];
      hp[s] = hp[last];
      ppos[hp[s]] = s;
      sift_up(s);
      sift_down(ppos[hp[s]]);
    end
  endfunction

  function automatic answer_t heap_apply(request_t rq);
    answer_t a;
    logic [5:0] lo, hi;
    logic [11:0] pi;
    bit ok;
    int s;
    logic [23:0] old;
    a = '{default: '0};
    lo = (rq.ga < rq.gb) ? rq.ga : rq.gb;
    hi = (rq.ga < rq.gb) ? rq.gb : rq.ga;
    ok = lo != hi;
    pi = {lo, hi};
    case (rq.op)
      ihp_pkg::OP_EXTRACT, ihp_pkg::OP_PEEK: begin
        if (hcount == 0) begin
          a.status = ihp_pkg::ST_EMPTY;
          a.min_key = '1;
        end else begin
          a.min_key = hk[0];
          {a.lo, a.hi} = hp[0];
          if (rq.op == ihp_pkg::OP_EXTRACT) begin
            pval[hp[0]] = 1'b0;
            fill_from_last(0);
          end
        end
      end
      ihp_pkg::OP_INSERT, ihp_pkg::OP_CHANGE, ihp_pkg::OP_REMOVE, ihp_pkg::OP_EXISTS: begin
        if (!ok) a.status = ihp_pkg::ST_BADPAIR;
        else if (rq.op == ihp_pkg::OP_INSERT) begin
          if (pval[pi]) a.status = ihp_pkg::ST_DUP;
          else if (hcount >= SLOTS) a.status = ihp_pkg::ST_FULL;
          else begin
            s = hcount++;
            hk[s] = rq.key;
            hp[s] = pi;
            ppos[pi] = s;
            pval[pi] = 1'b1;
            sift_up(s);
          end
        end else if (rq.op == ihp_pkg::OP_EXISTS) a.present = pval[pi];
        else if (!pval[pi] || ppos[pi] >= hcount) a.status = ihp_pkg::ST_NOTFOUND;
        else begin
          s = ppos[pi];
          if (rq.op == ihp_pkg::OP_CHANGE) begin
            old = hk[s];
            hk[s] = rq.key;
            if (rq.key < old) sift_up(s);
            else sift_down(s);
          end else begin
            pval[pi] = 1'b0;
            fill_from_last(s);
          end
        end
      end
      default: ;
    endcase
    a.total = hcount[11:0];
    return a;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 28);
  endfunction

  task automatic send(request_t rq, bit typed, answer_t want);
    answer_t a;
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.req_type <= rq.op;
    req_ch.key      <= rq.key;
    req_ch.group_a  <= rq.ga;
    req_ch.group_b  <= rq.gb;
    req_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    a = heap_apply(rq);
    if (typed && a != want) begin
      fails++;
      $display("row table disagrees with predictor: op %0d", rq.op);
    end
    pending.insert(pending.size(), a);
    sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) rsp_ch.ready <= rst ? 1'b0 : !(idle_now() || rsp_hold);

  always @(posedge clk) begin
    answer_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got++;
      if (pending.size() == 0) begin
        fails++;
        $display("unexpected response at %0t", $realtime);
      end else begin
        e = pending.pop_front();
        if (rsp_ch.status !== e.status || rsp_ch.min_key !== e.min_key ||
            rsp_ch.min_low_group !== e.lo || rsp_ch.min_high_group !== e.hi ||
            rsp_ch.present !== e.present || rsp_ch.entry_total !== e.total) begin
          fails++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d k=%0h %0d/%0d p=%0d n=%0d",
                     e.status, e.min_key, e.lo, e.hi, e.present, e.total,
                     " got st=%0d k=%0h %0d/%0d p=%0d n=%0d",
                     rsp_ch.status, rsp_ch.min_key, rsp_ch.min_low_group,
                     rsp_ch.min_high_group, rsp_ch.present, rsp_ch.entry_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic request_t mk(logic [2:0] op, logic [23:0] k, logic [5:0] a, logic [5:0] b);
    request_t r;
    r.op = op; r.key = k; r.ga = a; r.gb = b;
    return r;
  endfunction

  function automatic answer_t ans(logic [2:0] st, logic [23:0] k, logic [5:0] lo,
                                  logic [5:0] hi, logic p, logic [11:0] n);
    answer_t r;
    r.status = st; r.min_key = k; r.lo = lo; r.hi = hi; r.present = p; r.total = n;
    return r;
  endfunction

  function automatic void add_row(request_t rq, bit typed, answer_t want);
    row_t rw;
    rw.rq = rq;
    rw.typed = typed;
    rw.ans = want;
    rows.insert(rows.size(), rw);
  endfunction

  // pairs kept live in the random phase so change/remove hit often
  logic [11:0] live[$];

  function automatic request_t rand_request();
    request_t r;
    int pick, idx;
    logic [5:0] lo, hi;
    pick = $urandom_range(99);
    r.key = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(400));
    if ($urandom_range(19) == 0) r.key = $urandom_range(1) ? 24'hFFFFFF : 24'h0;
    r.ga = 6'($urandom_range(63));
    r.gb = 6'($urandom_range(63));
    if (live.size() > 0 && $urandom_range(1)) begin
      idx = $urandom_range(live.size() - 1);
      {lo, hi} = live[idx];
      if ($urandom_range(1)) {r.ga, r.gb} = {lo, hi};
      else {r.ga, r.gb} = {hi, lo};
    end
    if ($urandom_range(29) == 0) r.gb = r.ga;
    if (pick < 38) r.op = ihp_pkg::OP_INSERT;
    else if (pick < 55) r.op = ihp_pkg::OP_EXTRACT;
    else if (pick < 63) r.op = ihp_pkg::OP_PEEK;
    else if (pick < 80) r.op = ihp_pkg::OP_CHANGE;
    else if (pick < 90) r.op = ihp_pkg::OP_REMOVE;
    else if (pick < 97) r.op = ihp_pkg::OP_EXISTS;
    else r.op = 3'($urandom_range(6, 7));
    return r;
  endfunction

  initial begin
    answer_t none;
    request_t r;
    int wait_cycles;
    none = '{default: '0};
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.key = '0;
    req_ch.group_a = '0;
    req_ch.group_b = '0;
    rsp_ch.ready = 1'b0;
    rsp_hold = 1'b0;
    no_idle = 1'b0;
    fails = 0; mismatches = 0; sent = 0; got = 0;
    hcount = 0;
    foreach (pval[i]) begin
      pval[i] = 1'b0;
      ppos[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(mk(ihp_pkg::OP_PEEK, 0, 0, 0), 1, ans(ihp_pkg::ST_EMPTY, '1, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_EXTRACT, 0, 0, 0), 1, ans(ihp_pkg::ST_EMPTY, '1, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_INSERT, 5, 7, 7), 1, ans(ihp_pkg::ST_BADPAIR, 0, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_CHANGE, 5, 1, 2), 1, ans(ihp_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_REMOVE, 5, 1, 2), 1, ans(ihp_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_EXISTS, 5, 63, 0), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 0, 0));
    add_row(mk(ihp_pkg::OP_INSERT, 24'hFFFFFF, 63, 0), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_row(mk(ihp_pkg::OP_INSERT, 0, 0, 63), 1, ans(ihp_pkg::ST_DUP, 0, 0, 0, 0, 1));
    add_row(mk(ihp_pkg::OP_EXISTS, 0, 0, 63), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 1, 1));
    add_row(mk(ihp_pkg::OP_INSERT, 0, 21, 42), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 0, 2));
    add_row(mk(ihp_pkg::OP_PEEK, 0, 0, 0), 1, ans(ihp_pkg::ST_OK, 0, 21, 42, 0, 2));
    add_row(mk(ihp_pkg::OP_INSERT, 100, 42, 20), 0, none);
    add_row(mk(ihp_pkg::OP_INSERT, 100, 3, 9), 0, none);
    add_row(mk(ihp_pkg::OP_INSERT, 50, 11, 12), 0, none);
    add_row(mk(ihp_pkg::OP_CHANGE, 100, 3, 9), 0, none);
    add_row(mk(ihp_pkg::OP_CHANGE, 1, 63, 0), 0, none);
    add_row(mk(ihp_pkg::OP_CHANGE, 24'hFFFFFF, 21, 42), 0, none);
    add_row(mk(ihp_pkg::OP_REMOVE, 0, 12, 11), 0, none);
    add_row(mk(ihp_pkg::OP_REMOVE, 0, 20, 42), 0, none);
    add_row(mk(ihp_pkg::OP_EXISTS, 0, 5, 5), 1, ans(ihp_pkg::ST_BADPAIR, 0, 0, 0, 0, 3));
    add_row(mk(3'd6, 0, 1, 2), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 0, 3));
    add_row(mk(3'd7, 24'hFFFFFF, 63, 63), 1, ans(ihp_pkg::ST_OK, 0, 0, 0, 0, 3));
    add_row(mk(ihp_pkg::OP_EXTRACT, 0, 0, 0), 0, none);
    add_row(mk(ihp_pkg::OP_EXTRACT, 0, 0, 0), 0, none);
    add_row(mk(ihp_pkg::OP_EXTRACT, 0, 0, 0), 0, none);
    foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].ans);

    for (int n = 0; n < 900; n++) begin
      no_idle = (n >= 300 && n < 420);
      if (n == 500) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending.size() != 0) @(negedge clk);
      end
      // hold responses back for a while to back up the request side
      if (n == 600) begin
        fork
          begin
            @(posedge clk);
            rsp_hold = 1'b1;
            repeat (200) @(posedge clk);
            rsp_hold = 1'b0;
          end
        join_none
      end
      r = rand_request();
      if (r.op == ihp_pkg::OP_INSERT && r.ga != r.gb)
        live.insert(live.size(), r.ga < r.gb ? {r.ga, r.gb} : {r.gb, r.ga});
      if (live.size() > 60) void'(live.pop_front());
      send(r, 0, none);
    end
    req_ch.valid <= 1'b0;
    no_idle = 1'b0;

    wait_cycles = 0;
    while (pending.size() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (40) @(negedge clk);
    if (pending.size() != 0) fails++;
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
